@@ design/assert_macros.svh @@
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SCO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define SCO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent at the following edge.
`define SCO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sco_pkg.sv @@
// Package with constants, types and controller/datapath structs of the segment chain orderer.
`timescale 1ns / 1ps
package sco_pkg;

  localparam int MAX_SEGS    = 32;
  localparam int SEG_AW      = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int CNT_W       = $clog2(MAX_SEGS + 1);
  localparam int LEN_W       = $clog2(MAX_SEGS + 2);
  localparam int CHAIN_DEPTH = 64;
  localparam int CHAIN_AW    = $clog2(CHAIN_DEPTH);
  localparam int ID_W        = 32;

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_SEED_A,
    S_SEED_B,
    S_PASS,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FINISH,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMPTY
  } state_e;

  typedef struct packed {
    logic load;
    logic seed_rd;
    logic seed_a;
    logic seed_b;
    logic pass_start;
    logic scan_rd;
    logic scan_skip;
    logic scan_cmp;
    logic finish;
    logic emit_rd;
    logic emit_ld;
    logic emit_empty;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic left_zero;
    logic scan_end;
    logic scan_used;
    logic both_done;
    logic any_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

@@ design/sco_if.sv @@
// Handshake interfaces for the cell input channel and the point output channel.
`timescale 1ns / 1ps
interface sco_cell_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] point_a;
  logic [31:0] point_b;
  logic        last_cell;

  modport source (output valid, kind, point_a, point_b, last_cell, input ready);
  modport sink   (input valid, kind, point_a, point_b, last_cell, output ready);
endinterface

interface sco_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_id;
  logic        closed;
  logic        empty_res;
  logic        overflow;
  logic        last;

  modport source (output valid, point_id, closed, empty_res, overflow, last, input ready);
  modport sink   (input valid, point_id, closed, empty_res, overflow, last, output ready);
endinterface

@@ design/sco_ctrl.sv @@
// Controller state machine: sequences loading, seeding, chaining passes and emission.
`timescale 1ns / 1ps
module sco_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  sco_pkg::sts_t sts_i,
  output sco_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);
  import sco_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (sts_i.count_zero) begin
          state_d = S_EMPTY;
        end else begin
          cmd_o.seed_rd = 1'b1;
          state_d       = S_SEED_A;
        end
      end
      S_SEED_A: begin
        cmd_o.seed_a = 1'b1;
        state_d      = S_SEED_B;
      end
      S_SEED_B: begin
        cmd_o.seed_b = 1'b1;
        state_d      = sts_i.left_zero ? S_FINISH : S_PASS;
      end
      S_PASS: begin
        cmd_o.pass_start = 1'b1;
        state_d          = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        if (sts_i.scan_end || sts_i.both_done) begin
          // A pass that attached nothing, or a store used up, ends chaining.
          if (!sts_i.any_done || sts_i.left_zero) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_PASS;
          end
        end else if (sts_i.scan_used) begin
          cmd_o.scan_skip = 1'b1;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = S_SCAN_RD;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_LOAD;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.emit_empty = 1'b1;
          cmd_o.clear      = 1'b1;
          state_d          = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

@@ design/sco_dp.sv @@
// Datapath: segment store, chain buffer, chain ends, counters and the output register.
`timescale 1ns / 1ps
module sco_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sco_pkg::cmd_t  cmd_i,
  output sco_pkg::sts_t  sts_o,
  input  logic           kind_i,
  input  sco_pkg::id_t   point_a_i,
  input  sco_pkg::id_t   point_b_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output sco_pkg::id_t   point_id_o,
  output logic           closed_o,
  output logic           empty_res_o,
  output logic           overflow_o,
  output logic           last_o
);
  import sco_pkg::*;

  // Memories
  logic [2*ID_W-1:0] seg_mem [MAX_SEGS];
  id_t               chain_mem [CHAIN_DEPTH];
  logic [2*ID_W-1:0] seg_rd_q;
  id_t               ch_rd_q;

  // Control registers
  logic [CNT_W-1:0]    count_q, idx_q, left_q;
  logic [LEN_W-1:0]    len_q, k_q;
  logic [CHAIN_AW-1:0] head_q, tail_q;
  logic [MAX_SEGS-1:0] used_q;
  logic                stopped_q, ovf_q, fdone_q, bdone_q, closed_q, out_valid_q;

  // Payload registers
  id_t front_q, back_q, pass_first_q, pass_back_q;
  id_t out_id_q;
  logic out_closed_q, out_empty_q, out_ovf_q, out_last_q;

  // Combinational
  id_t                 seg_a, seg_b, other_f, other_b;
  logic                front_hit, back_hit, store_en, emit_last, out_free;
  logic                ch_we;
  logic [CHAIN_AW-1:0] ch_wa, ch_ra;
  id_t                 ch_wd;
  logic [SEG_AW-1:0]   seg_ra;

  assign seg_a     = seg_rd_q[2*ID_W-1:ID_W];
  assign seg_b     = seg_rd_q[ID_W-1:0];
  assign other_f   = (pass_first_q == seg_a) ? seg_b : seg_a;
  assign other_b   = (pass_back_q == seg_a) ? seg_b : seg_a;
  assign front_hit = !fdone_q && ((pass_first_q == seg_a) || (pass_first_q == seg_b));
  assign back_hit  = !front_hit && !bdone_q &&
                     ((pass_back_q == seg_a) || (pass_back_q == seg_b));
  assign store_en  = cmd_i.load && !stopped_q && !kind_i && (count_q < CNT_W'(MAX_SEGS));
  assign emit_last = (LEN_W'(k_q + 1'b1) == len_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign seg_ra    = cmd_i.scan_rd ? idx_q[SEG_AW-1:0] : '0;
  assign ch_ra     = head_q + CHAIN_AW'(k_q);

  always_comb begin
    ch_we = 1'b0;
    ch_wa = '0;
    ch_wd = seg_a;
    if (cmd_i.seed_a) begin
      ch_we = 1'b1;
    end else if (cmd_i.seed_b) begin
      ch_we = 1'b1;
      ch_wa = CHAIN_AW'(1);
      ch_wd = seg_b;
    end else if (cmd_i.scan_cmp && front_hit) begin
      ch_we = 1'b1;
      ch_wa = head_q - CHAIN_AW'(1);
      ch_wd = other_f;
    end else if (cmd_i.scan_cmp && back_hit) begin
      ch_we = 1'b1;
      ch_wa = tail_q;
      ch_wd = other_b;
    end
  end

  always_comb begin
    sts_o.count_zero = (count_q == '0);
    sts_o.left_zero  = (left_q == '0);
    sts_o.scan_end   = (idx_q == count_q);
    sts_o.scan_used  = used_q[idx_q[SEG_AW-1:0]];
    sts_o.both_done  = fdone_q && bdone_q;
    sts_o.any_done   = fdone_q || bdone_q;
    sts_o.emit_last  = emit_last;
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      left_q      <= '0;
      len_q       <= '0;
      k_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      used_q      <= '0;
      stopped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      fdone_q     <= 1'b0;
      bdone_q     <= 1'b0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && !stopped_q) begin
        if (kind_i) begin
          stopped_q <= 1'b1;
        end else if (store_en) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.seed_rd) begin
        left_q <= count_q - 1'b1;
      end
      if (cmd_i.seed_a) begin
        head_q <= '0;
        tail_q <= CHAIN_AW'(1);
      end
      if (cmd_i.seed_b) begin
        tail_q    <= CHAIN_AW'(2);
        used_q[0] <= 1'b1;
        len_q     <= LEN_W'(2);
      end
      if (cmd_i.pass_start) begin
        idx_q   <= CNT_W'(1);
        fdone_q <= 1'b0;
        bdone_q <= 1'b0;
      end
      if (cmd_i.scan_skip) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.scan_cmp) begin
        idx_q <= idx_q + 1'b1;
        if (front_hit) begin
          head_q  <= head_q - CHAIN_AW'(1);
          fdone_q <= 1'b1;
        end else if (back_hit) begin
          tail_q  <= tail_q + CHAIN_AW'(1);
          bdone_q <= 1'b1;
        end
        if (front_hit || back_hit) begin
          used_q[idx_q[SEG_AW-1:0]] <= 1'b1;
          left_q <= left_q - 1'b1;
          len_q  <= len_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        closed_q <= (front_q == back_q);
        k_q      <= '0;
        if (front_q == back_q) begin
          len_q <= len_q - 1'b1;
        end
      end
      if (cmd_i.emit_ld) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.emit_ld || cmd_i.emit_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        count_q   <= '0;
        head_q    <= '0;
        tail_q    <= '0;
        used_q    <= '0;
        stopped_q <= 1'b0;
        ovf_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      seg_mem[count_q[SEG_AW-1:0]] <= {point_a_i, point_b_i};
    end
    if (cmd_i.seed_rd || cmd_i.scan_rd) begin
      seg_rd_q <= seg_mem[seg_ra];
    end
    if (ch_we) begin
      chain_mem[ch_wa] <= ch_wd;
    end
    if (cmd_i.emit_rd) begin
      ch_rd_q <= chain_mem[ch_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_a) begin
      front_q <= seg_a;
    end
    if (cmd_i.seed_b) begin
      back_q <= seg_b;
    end
    if (cmd_i.scan_cmp && front_hit) begin
      front_q <= other_f;
    end
    if (cmd_i.scan_cmp && back_hit) begin
      back_q <= other_b;
    end
    if (cmd_i.pass_start) begin
      pass_first_q <= front_q;
      pass_back_q  <= back_q;
    end
    if (cmd_i.emit_ld) begin
      out_id_q     <= ch_rd_q;
      out_closed_q <= closed_q;
      out_empty_q  <= 1'b0;
      out_ovf_q    <= ovf_q;
      out_last_q   <= emit_last;
    end else if (cmd_i.emit_empty) begin
      out_id_q     <= '0;
      out_closed_q <= 1'b0;
      out_empty_q  <= 1'b1;
      out_ovf_q    <= ovf_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_id_o  = out_id_q;
  assign closed_o    = out_closed_q;
  assign empty_res_o = out_empty_q;
  assign overflow_o  = out_ovf_q;
  assign last_o      = out_last_q;

endmodule

@@ design/segment_chain_orderer_top.sv @@
// Top level of the segment chain orderer: controller and datapath.
`timescale 1ns / 1ps
// Cells are taken one per cycle while the block loads; up to MAX_SEGS two-point cells are
// kept and later ones are dropped with the overflow flag set. After the cell with last_cell
// the input stalls while the chain is built: S_START, S_SEED_A and S_SEED_B seed the chain,
// then each pass walks the segment store through its single registered read port, skipping
// a used segment in S_SCAN_RD and reading and comparing an unused one in S_SCAN_RD and
// S_SCAN_CMP; at most one pass per stored segment runs. Each chain point is then emitted by
// a chain buffer read and an output register load, the load waiting for a free output. The
// last point word sits in the output register while the next set of cells is already accepted.
module segment_chain_orderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sco_cell_if.sink    cell_i,
  sco_pt_if.source    pt_o
);
  import sco_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  sco_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cell_i.valid),
    .in_last_i  (cell_i.last_cell),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  sco_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (cell_i.kind),
    .point_a_i   (cell_i.point_a),
    .point_b_i   (cell_i.point_b),
    .out_ready_i (pt_o.ready),
    .out_valid_o (pt_o.valid),
    .point_id_o  (pt_o.point_id),
    .closed_o    (pt_o.closed),
    .empty_res_o (pt_o.empty_res),
    .overflow_o  (pt_o.overflow),
    .last_o      (pt_o.last)
  );

  assign cell_i.ready = in_ready;

endmodule

@@ design/sco_checker.sv @@
// Port-level checker of the segment chain orderer and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sco_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] point_id_i,
  input logic        closed_i,
  input logic        empty_res_i,
  input logic        last_i
);

  // A stalled output word holds its point id and last flag.
  `SCO_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(point_id_i) && $stable(last_i), "output word changed while stalled")

  // An empty result is a single word with a zero point id.
  `SCO_ASSERT_IMP(a_empty_single, clk_i, rst_ni, out_valid_i && empty_res_i, last_i && !closed_i && (point_id_i == 32'd0), "malformed empty result")

  // No cell is taken while a chain is still being emitted.
  `SCO_ASSERT(a_no_load_in_emit, clk_i, rst_ni, !(out_valid_i && !last_i && in_ready_i), "cell input open during emission")

  // The final cell of a set closes the input for chaining.
  `SCO_ASSERT_NXT(a_last_stalls, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "input still open after the final cell")

  // Ordinary cells keep the input open.
  `SCO_ASSERT_NXT(a_load_streams, clk_i, rst_ni, in_valid_i && in_ready_i && !in_last_i, in_ready_i, "input closed in the middle of a set")

endmodule

bind segment_chain_orderer_top sco_checker u_sco_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cell_i.valid),
  .in_ready_i  (cell_i.ready),
  .in_last_i   (cell_i.last_cell),
  .out_valid_i (pt_o.valid),
  .out_ready_i (pt_o.ready),
  .point_id_i  (pt_o.point_id),
  .closed_i    (pt_o.closed),
  .empty_res_i (pt_o.empty_res),
  .last_i      (pt_o.last)
);

@@ sim/segment_chain_orderer_top_test.sv @@
// Self-checking testbench of the segment chain orderer with a scoreboard class and random idling.
`timescale 1ns / 1ps
module segment_chain_orderer_top_test;
  import sco_pkg::*;

  localparam bit CELL_LINE  = 1'b0;
  localparam bit CELL_OTHER = 1'b1;
  localparam int RANDOM_CELLS = 500;

  typedef struct packed {
    logic kind;
    id_t  point_a;
    id_t  point_b;
    logic last_cell;
  } cell_t;

  typedef struct packed {
    id_t  point_id;
    logic closed;
    logic empty_res;
    logic overflow;
    logic last;
  } point_t;

  // Mirrors the block: collects segments of one set and predicts the ordered chain.
  class chain_scoreboard;
    id_t         seg_a[MAX_SEGS];
    id_t         seg_b[MAX_SEGS];
    bit          seg_used[MAX_SEGS];
    int unsigned seg_count;
    bit          reading_done;
    bit          dropped;
    point_t      expected_points[$];
    int unsigned errors;
    int unsigned points_checked;
    int unsigned sets_done;
    int unsigned sets_closed;
    int unsigned sets_dropped;
    int unsigned sets_empty;

    function void clear_set();
      foreach (seg_used[i]) seg_used[i] = 1'b0;
      seg_count    = 0;
      reading_done = 1'b0;
      dropped      = 1'b0;
    endfunction

    function void order_chain();
      id_t         chain[$];
      id_t         front;
      id_t         back;
      int unsigned left;
      bit          front_done;
      bit          back_done;
      bit          loop;
      point_t      p;
      sets_done++;
      if (dropped) sets_dropped++;
      if (seg_count == 0) begin
        sets_empty++;
        p.point_id  = '0;
        p.closed    = 1'b0;
        p.empty_res = 1'b1;
        p.overflow  = dropped;
        p.last      = 1'b1;
        expected_points = {expected_points, p};
        return;
      end
      chain = {seg_a[0], seg_b[0]};
      seg_used[0] = 1'b1;
      left = seg_count - 1;
      // Each pass grows the chain by at most one segment at either end.
      while (left > 0) begin
        front      = chain[0];
        back       = chain[chain.size() - 1];
        front_done = 1'b0;
        back_done  = 1'b0;
        for (int unsigned i = 1; i < seg_count; i++) begin
          if (front_done && back_done) break;
          if (seg_used[i]) continue;
          if (!front_done && (front == seg_a[i] || front == seg_b[i])) begin
            chain = {(front == seg_a[i] ? seg_b[i] : seg_a[i]), chain};
            front_done = 1'b1;
          end else if (!back_done && (back == seg_a[i] || back == seg_b[i])) begin
            chain = {chain, (back == seg_a[i] ? seg_b[i] : seg_a[i])};
            back_done = 1'b1;
          end else begin
            continue;
          end
          seg_used[i] = 1'b1;
          left--;
        end
        if (!front_done && !back_done) break;
      end
      loop = (chain[0] == chain[chain.size() - 1]);
      if (loop) begin
        chain.delete(chain.size() - 1);
        sets_closed++;
      end
      foreach (chain[k]) begin
        p.point_id  = chain[k];
        p.closed    = loop;
        p.empty_res = 1'b0;
        p.overflow  = dropped;
        p.last      = (k == chain.size() - 1);
        expected_points = {expected_points, p};
      end
    endfunction

    function void note_cell(cell_t c);
      if (!reading_done) begin
        if (c.kind == CELL_OTHER) begin
          reading_done = 1'b1;
        end else if (seg_count < MAX_SEGS) begin
          seg_a[seg_count] = c.point_a;
          seg_b[seg_count] = c.point_b;
          seg_count++;
        end else begin
          dropped = 1'b1;
        end
      end
      if (c.last_cell) begin
        order_chain();
        clear_set();
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        $error("unexpected point word: point_id %0h last %0b", got.point_id, got.last);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      points_checked++;
      if (got.point_id !== want.point_id) begin
        $error("point_id mismatch: expected %0h, actual %0h", want.point_id, got.point_id);
        errors++;
      end
      if (got.closed !== want.closed) begin
        $error("closed mismatch: expected %0b, actual %0b", want.closed, got.closed);
        errors++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res mismatch: expected %0b, actual %0b", want.empty_res, got.empty_res);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, got.overflow);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function void finish_check();
      if (expected_points.size() != 0) begin
        $error("%0d point words never arrived", expected_points.size());
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  chain_scoreboard sb;

  sco_cell_if cell_if ();
  sco_pt_if   pt_if ();

  segment_chain_orderer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_if),
    .pt_o   (pt_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: check each accepted point word, then pick the next ready value.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        sb.check_point({pt_if.point_id, pt_if.closed, pt_if.empty_res, pt_if.overflow,
                        pt_if.last});
      end
      pt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic cell_t mk_cell(bit kind, id_t a, id_t b, bit last_cell);
    cell_t c;
    c.kind      = kind;
    c.point_a   = a;
    c.point_b   = b;
    c.last_cell = last_cell;
    return c;
  endfunction

  function automatic id_t rand_id(bit narrow);
    if (narrow) return id_t'($urandom_range(0, 7));
    if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
    return id_t'($urandom());
  endfunction

  // Valid stays high from one word to the next unless an idle cycle is drawn.
  task automatic send_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cell_if.valid     <= 1'b1;
    cell_if.kind      <= c.kind;
    cell_if.point_a   <= c.point_a;
    cell_if.point_b   <= c.point_b;
    cell_if.last_cell <= c.last_cell;
    do @(posedge clk_i); while (!cell_if.ready);
    sb.note_cell(c);
  endtask

  task automatic run_set(cell_t cells[$]);
    foreach (cells[i]) send_cell(cells[i]);
  endtask

  // One random set; returns how many cells the block actually reads.
  task automatic random_set(output int unsigned counted);
    cell_t       cells[$];
    id_t         path[$];
    cell_t       c;
    cell_t       tmp;
    int unsigned nseg;
    int unsigned r;
    int unsigned j;
    int unsigned stop_at;
    bit          narrow;
    r = $urandom_range(99);
    nseg = (r < 80) ? $urandom_range(1, 8) : (r < 92) ? $urandom_range(9, 31)
                                                       : $urandom_range(32, 40);
    if ($urandom_range(99) < 70) begin
      // Well-formed path or loop, cut into segments with random orientation.
      for (j = 0; j <= nseg; j++) path = {path, rand_id(1'b0)};
      if ($urandom_range(1) && nseg >= 2) path[nseg] = path[0];
      for (j = 0; j < nseg; j++) begin
        if ($urandom_range(1)) cells = {cells, mk_cell(CELL_LINE, path[j], path[j+1], 1'b0)};
        else cells = {cells, mk_cell(CELL_LINE, path[j+1], path[j], 1'b0)};
      end
      if ($urandom_range(99) < 70) begin
        for (j = cells.size() - 1; j > 0; j--) begin
          r        = $urandom_range(j);
          tmp      = cells[j];
          cells[j] = cells[r];
          cells[r] = tmp;
        end
      end
    end else begin
      narrow = ($urandom_range(99) < 60);
      for (j = 0; j < nseg; j++) begin
        cells = {cells, mk_cell(CELL_LINE, rand_id(narrow), rand_id(narrow), 1'b0)};
      end
    end
    counted = cells.size();
    if ($urandom_range(99) < 15) begin
      // A non-line cell ends reading; everything after it is ignored.
      stop_at = $urandom_range(cells.size());
      cells.insert(stop_at, mk_cell(CELL_OTHER, rand_id(1'b0), rand_id(1'b0), 1'b0));
      for (j = stop_at + 1; j < cells.size(); j++) cells[j].kind = 1'($urandom_range(1));
      counted = stop_at + 1;
    end
    if ($urandom_range(9) == 0) begin
      c = mk_cell(CELL_OTHER, rand_id(1'b0), rand_id(1'b0), 1'b1);
      if (counted == cells.size()) counted++;
      cells = {cells, c};
    end else begin
      cells[cells.size() - 1].last_cell = 1'b1;
    end
    run_set(cells);
  endtask

  initial begin
    cell_t       dir[$];
    int unsigned random_items;
    int unsigned n;
    int unsigned phase;
    sb = new();
    sb.clear_set();
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst_ni            <= 1'b0;
    cell_if.valid     <= 1'b0;
    cell_if.kind      <= CELL_LINE;
    cell_if.point_a   <= '0;
    cell_if.point_b   <= '0;
    cell_if.last_cell <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty set: the only cell is a non-line cell carrying the end marker.
    dir = {dir, mk_cell(CELL_OTHER, '1, '1, 1'b1)};
    run_set(dir);
    dir.delete();
    // Single segment with the extreme ids.
    dir = {dir, mk_cell(CELL_LINE, '0, '1, 1'b1)};
    run_set(dir);
    dir.delete();
    // Degenerate segment that closes on itself.
    dir = {dir, mk_cell(CELL_LINE, 32'h5555_5555, 32'h5555_5555, 1'b1)};
    run_set(dir);
    dir.delete();
    // Triangle with mixed orientation forms a closed loop.
    dir = {dir, mk_cell(CELL_LINE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 32'h0000_0003, 32'h5555_5555, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 32'h0000_0003, 32'hAAAA_AAAA, 1'b1)};
    run_set(dir);
    dir.delete();
    // Open path given out of order; one pass grows both ends.
    dir = {dir, mk_cell(CELL_LINE, 40, 41, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 39, 40, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 41, 42, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 43, 44, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 38, 39, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 42, 43, 1'b1)};
    run_set(dir);
    dir.delete();
    // Reading stops mid-set; later cells, the marker cell too, are ignored.
    dir = {dir, mk_cell(CELL_LINE, 30, 31, 1'b0)};
    dir = {dir, mk_cell(CELL_OTHER, 31, 32, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 31, 32, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 30, 29, 1'b1)};
    run_set(dir);
    dir.delete();
    // Disconnected segments: the chain stops after the seed.
    dir = {dir, mk_cell(CELL_LINE, 50, 51, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 60, 61, 1'b1)};
    run_set(dir);
    dir.delete();
    // Segments followed by a non-line marker cell.
    dir = {dir, mk_cell(CELL_LINE, 70, 71, 1'b0)};
    dir = {dir, mk_cell(CELL_LINE, 72, 71, 1'b0)};
    dir = {dir, mk_cell(CELL_OTHER, 0, 0, 1'b1)};
    run_set(dir);
    dir.delete();

    random_items = 0;
    while (random_items < RANDOM_CELLS) begin
      phase = random_items * 4 / RANDOM_CELLS;
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 66;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 66;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      random_set(n);
      random_items += n;
    end
    cell_if.valid <= 1'b0;

    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    sb.finish_check();

    $display("Ran %0d cell sets: %0d closed loops, %0d with dropped segments, %0d empty.",
             sb.sets_done, sb.sets_closed, sb.sets_dropped, sb.sets_empty);
    $display("Checked %0d point words under four idling patterns.", sb.points_checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
